// ===== rtl/lsfg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfg_pkg
// Shared types and constants for the LED strip frame generator.
// ----------------------------------------------------------------------------
package lsfg_pkg;

    // Store geometry and register widths
    localparam int MAX_LEDS = 256;
    localparam int PIX_AW   = $clog2(MAX_LEDS);
    localparam int COUNT_W  = 9;
    localparam int PARAM_W  = 8;
    localparam int COLOR_W  = 24;
    localparam int WORD_W   = 32;

    localparam logic [PARAM_W-1:0] PARAM_RESET = 8'hFF;
    localparam logic [WORD_W-1:0]  START_WORD  = 32'h0000_0000;
    localparam logic [WORD_W-1:0]  END_WORD    = 32'hFFFF_FFFF;

    // Command codes
    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NEXT  = 2'd3
    } cmd_code_t;

    // Configuration register indexes
    typedef enum logic {
        REG_LED_COUNT = 1'b0,
        REG_LED_PARAM = 1'b1
    } cfg_index_t;

    // Kind of frame word being built
    typedef enum logic [1:0] {
        WORD_START,
        WORD_LED,
        WORD_END
    } word_kind_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Input command payload
    typedef struct packed {
        cmd_code_t  cmd;
        logic [7:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } command_t;

    // Result payload
    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic [WORD_W-1:0]  frame_word;
        logic               word_valid;
        logic               frame_last;
    } result_t;

    // Pixel memory access request
    typedef struct packed {
        logic               wr_en;
        logic [PIX_AW-1:0]  wr_addr;
        logic [COLOR_W-1:0] wr_data;
        logic               rd_en;
        logic [PIX_AW-1:0]  rd_addr;
        logic               clear;
    } ram_req_t;

endpackage
`default_nettype wire

// ===== rtl/lsfg_pixel_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfg_pixel_ram
// Pixel memory with registered read and per-entry valid bits;
// an entry that is not valid reads as zero, so clear takes effect at once.
// ----------------------------------------------------------------------------
module lsfg_pixel_ram (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lsfg_pkg::ram_req_t            req,
    output logic [lsfg_pkg::COLOR_W-1:0]       rd_data
);

    logic [lsfg_pkg::COLOR_W-1:0] mem [lsfg_pkg::MAX_LEDS];
    logic [lsfg_pkg::COLOR_W-1:0] rd_data_reg;
    logic [lsfg_pkg::MAX_LEDS-1:0] valid_reg;
    logic [lsfg_pkg::MAX_LEDS-1:0] valid_next;
    logic                          rd_valid_reg;

    // Drop all valid bits on clear, mark written entries
    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
        begin
            valid_next = '0;
        end
        else if (req.wr_en)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // Write and read the color array
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

// ===== rtl/led_strip_frame_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_strip_frame_generator
// Pixel store and LED strip frame builder driven by one command at a time.
// ----------------------------------------------------------------------------
// The accept edge issues the pixel memory read (or write). The following
// cycle presents the result, with done high for exactly that one cycle and
// busy also high. Busy drops at the edge that ends the result cycle; a new
// command is accepted only once busy is low, so a command cannot start
// while the last one is still presenting its result. The receiver cannot
// stall: capture result whenever done is high. Clear and led_count writes
// reset the per-pixel valid bits at once, so there is no clearing pass.
// Configuration writes are ready only while no command is in flight and
// none is being started.
module led_strip_frame_generator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire lsfg_pkg::command_t            command,
    output logic                               done,
    output lsfg_pkg::result_t                  result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [lsfg_pkg::COUNT_W-1:0]  cfg_data
);

    lsfg_pkg::state_t   state_reg, state_next;
    lsfg_pkg::cmd_code_t op_reg, op_next;
    lsfg_pkg::word_kind_t kind_reg, kind_next;
    logic               in_range_reg, in_range_next;
    logic [lsfg_pkg::COUNT_W-1:0] frame_pos_reg, frame_pos_next;
    logic [lsfg_pkg::COUNT_W-1:0] led_count_reg, led_count_next;
    logic [lsfg_pkg::PARAM_W-1:0] led_param_reg, led_param_next;
    logic [lsfg_pkg::COLOR_W-1:0] pix_data;
    lsfg_pkg::ram_req_t ram_req;
    logic               accept;
    logic               cfg_write;
    logic               idx_ok;

    assign accept    = start && (state_reg == lsfg_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == lsfg_pkg::ST_IDLE) && !start;
    assign cfg_write = cfg_valid && cfg_ready;
    assign idx_ok    = {1'b0, command.led_index} < led_count_reg;

    // Sequence the command, update frame position and registers
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        kind_next      = kind_reg;
        in_range_next  = in_range_reg;
        frame_pos_next = frame_pos_reg;
        led_count_next = led_count_reg;
        led_param_next = led_param_reg;

        ram_req         = '0;
        ram_req.wr_addr = lsfg_pkg::PIX_AW'(command.led_index);
        ram_req.wr_data = {command.red, command.green, command.blue};
        ram_req.rd_addr = lsfg_pkg::PIX_AW'(command.led_index);

        case (state_reg)
            lsfg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = lsfg_pkg::ST_EXEC;
                    op_next       = command.cmd;
                    in_range_next = idx_ok;
                    case (command.cmd)
                        lsfg_pkg::CMD_SET:
                        begin
                            ram_req.wr_en = idx_ok;
                        end
                        lsfg_pkg::CMD_GET:
                        begin
                            ram_req.rd_en = 1'b1;
                        end
                        lsfg_pkg::CMD_CLEAR:
                        begin
                            ram_req.clear = 1'b1;
                        end
                        default:
                        begin
                            // Next frame word: pick start, LED or end word
                            if (frame_pos_reg == '0)
                            begin
                                kind_next      = lsfg_pkg::WORD_START;
                                frame_pos_next = frame_pos_reg + 1'b1;
                            end
                            else if (frame_pos_reg <= led_count_reg)
                            begin
                                kind_next       = lsfg_pkg::WORD_LED;
                                frame_pos_next  = frame_pos_reg + 1'b1;
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr =
                                    lsfg_pkg::PIX_AW'(frame_pos_reg - 1'b1);
                            end
                            else
                            begin
                                kind_next      = lsfg_pkg::WORD_END;
                                frame_pos_next = '0;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = lsfg_pkg::ST_IDLE;
            end
        endcase

        // Apply configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                lsfg_pkg::REG_LED_COUNT:
                begin
                    if (cfg_data > lsfg_pkg::COUNT_W'(lsfg_pkg::MAX_LEDS))
                    begin
                        led_count_next = lsfg_pkg::COUNT_W'(lsfg_pkg::MAX_LEDS);
                    end
                    else
                    begin
                        led_count_next = cfg_data;
                    end
                    frame_pos_next = '0;
                    ram_req.clear  = 1'b1;
                end
                default:
                begin
                    led_param_next = cfg_data[lsfg_pkg::PARAM_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsfg_pkg::ST_IDLE;
            op_reg        <= lsfg_pkg::CMD_SET;
            kind_reg      <= lsfg_pkg::WORD_START;
            in_range_reg  <= 1'b0;
            frame_pos_reg <= '0;
            led_count_reg <= '0;
            led_param_reg <= lsfg_pkg::PARAM_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            kind_reg      <= kind_next;
            in_range_reg  <= in_range_next;
            frame_pos_reg <= frame_pos_next;
            led_count_reg <= led_count_next;
            led_param_reg <= led_param_next;
        end
    end

    lsfg_pixel_ram u_pixel_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (pix_data)
    );

    // Build the result transaction in the result cycle
    always_comb
    begin
        result = '0;
        case (op_reg)
            lsfg_pkg::CMD_GET:
            begin
                result.read_color = in_range_reg ? pix_data : '0;
            end
            lsfg_pkg::CMD_NEXT:
            begin
                result.word_valid = 1'b1;
                case (kind_reg)
                    lsfg_pkg::WORD_START:
                    begin
                        result.frame_word = lsfg_pkg::START_WORD;
                    end
                    lsfg_pkg::WORD_LED:
                    begin
                        result.frame_word = {led_param_reg, pix_data[7:0],
                                             pix_data[15:8], pix_data[23:16]};
                    end
                    default:
                    begin
                        result.frame_word = lsfg_pkg::END_WORD;
                        result.frame_last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    assign done = (state_reg == lsfg_pkg::ST_EXEC);
    assign busy = (state_reg == lsfg_pkg::ST_EXEC);

endmodule
`default_nettype wire
